@@ design/assert_macros.svh @@
// Assertion macros shared by the color generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/grhc_pkg.sv @@
// Shared constants, types and helpers of the golden-ratio hue color generator.
package grhc_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int SEED_BITS    = 16;
    localparam int Q16_BITS     = 16;

    localparam logic [63:0] GOLDEN_FRAC64 = 64'h9E3779B97F4A7C15;

    // Golden fraction rounded to nearest at HUE_BITS.
    localparam logic [HUE_BITS-1:0] GOLDEN_STEP = HUE_BITS'(
        (GOLDEN_FRAC64 >> (64 - HUE_BITS)) + ((GOLDEN_FRAC64 >> (63 - HUE_BITS)) & 64'd1));

    localparam logic [Q16_BITS-1:0] VALUE_Q16     = 16'd62259;
    localparam logic [Q16_BITS-1:0] SAT_LIGHT_Q16 = 16'd32768;
    localparam logic [Q16_BITS-1:0] SAT_DARK_Q16  = 16'd58982;

    // Levels are Q0.16 with 1.0 = 2^16, so they need one extra bit.
    localparam int LEVEL_BITS = Q16_BITS + 1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << Q16_BITS;

    localparam int CHAN_MAX   = (1 << CHANNEL_BITS) - 1;
    localparam int SCALE_BITS = Q16_BITS + CHANNEL_BITS;
    localparam logic [SCALE_BITS-1:0] CHAN_SCALE = SCALE_BITS'(62259 * CHAN_MAX);
    localparam int CHAN_PROD_BITS = LEVEL_BITS + SCALE_BITS + 1;
    localparam int CHAN_SHIFT     = 2 * Q16_BITS;

    // Largest channel code: value 0.95 at full level.
    localparam logic [CHANNEL_BITS-1:0] CHAN_PEAK =
        CHANNEL_BITS'((62259 * CHAN_MAX + (1 << (Q16_BITS - 1))) >> Q16_BITS);

    typedef logic [LEVEL_BITS-1:0]   level_t;
    typedef logic [CHANNEL_BITS-1:0] channel_t;

    // Hue sextants, named by the hue range they cover.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [HUE_BITS-1:0] frac;
        logic                dark;
    } hue_item_t;

    typedef struct packed {
        level_t r;
        level_t g;
        level_t b;
    } rgb_levels_t;

    // Realign a Q0.16 seed to HUE_BITS: shift left when wider, truncate when narrower.
    function automatic logic [HUE_BITS-1:0] align_seed(input logic [SEED_BITS-1:0] seed);
        logic [SEED_BITS+HUE_BITS-1:0] wide;
        wide = {seed, HUE_BITS'(0)};
        return wide[SEED_BITS+HUE_BITS-1 -: HUE_BITS];
    endfunction

endpackage

@@ design/grhc_hue_gen.sv @@
// Hue phase accumulator, seed register and input stage with sextant split.
`include "assert_macros.svh"

module grhc_hue_gen
    import grhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [SEED_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 dark_palette,
    output logic                 item_valid,
    input  logic                 item_ready,
    output hue_item_t            item
);

    logic [SEED_BITS-1:0]   seed_reg;
    logic [HUE_BITS-1:0]    phase_reg;
    logic [HUE_BITS-1:0]    phase_next;
    logic [HUE_BITS-1:0]    hue;
    logic [HUE_BITS+2:0]    hue6;
    logic                   valid_reg;
    logic                   valid_next;
    hue_item_t              item_reg;
    hue_item_t              item_next;
    logic                   accept;

    assign in_ready = !valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg + GOLDEN_STEP;
        hue        = align_seed(seed_reg) + phase_next;
        // hue * 6 as two shifts and an add
        hue6       = ((HUE_BITS + 3)'(hue) << 2) + ((HUE_BITS + 3)'(hue) << 1);
        item_next.sector = sector_t'(hue6[HUE_BITS +: 3]);
        item_next.frac   = hue6[HUE_BITS-1:0];
        item_next.dark   = dark_palette;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    `ASSERT_NEXT(a_phase_step, clk, rst_n, accept, phase_reg == HUE_BITS'($past(phase_reg) + GOLDEN_STEP))
    `ASSERT_NEXT(a_stage_loaded, clk, rst_n, accept, valid_reg)

endmodule

@@ design/grhc_level_stage.sv @@
// Saturation scaling and six-sextant level selection.
`include "assert_macros.svh"

module grhc_level_stage
    import grhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  hue_item_t   item,
    output logic        lvl_valid,
    input  logic        lvl_ready,
    output rgb_levels_t lvl
);

    localparam int SF_PROD_BITS = Q16_BITS + HUE_BITS + 1;

    logic [Q16_BITS-1:0]     sat;
    logic [SF_PROD_BITS-1:0] sf_prod;
    logic [Q16_BITS-1:0]     sf_raw;
    logic [Q16_BITS-1:0]     sf;
    level_t                  lev_p;
    level_t                  lev_q;
    level_t                  lev_t;
    rgb_levels_t             lvl_next;
    rgb_levels_t             lvl_reg;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    load;

    assign item_ready = !valid_reg || lvl_ready;
    assign load       = item_valid && item_ready;

    always_comb
    begin
        sat     = item.dark ? SAT_DARK_Q16 : SAT_LIGHT_Q16;
        sf_prod = SF_PROD_BITS'(sat) * SF_PROD_BITS'(item.frac)
                + (SF_PROD_BITS'(1) << (HUE_BITS - 1));
        sf_raw  = sf_prod[HUE_BITS +: Q16_BITS];
        sf      = (sf_raw > sat) ? sat : sf_raw;
        lev_p   = LEVEL_ONE - LEVEL_BITS'(sat);
        lev_q   = LEVEL_ONE - LEVEL_BITS'(sf);
        lev_t   = LEVEL_ONE - LEVEL_BITS'(sat) + LEVEL_BITS'(sf);
        unique case (item.sector)
            SEC_RED_YELLOW:
            begin
                lvl_next = '{r: LEVEL_ONE, g: lev_t, b: lev_p};
            end
            SEC_YELLOW_GREEN:
            begin
                lvl_next = '{r: lev_q, g: LEVEL_ONE, b: lev_p};
            end
            SEC_GREEN_CYAN:
            begin
                lvl_next = '{r: lev_p, g: LEVEL_ONE, b: lev_t};
            end
            SEC_CYAN_BLUE:
            begin
                lvl_next = '{r: lev_p, g: lev_q, b: LEVEL_ONE};
            end
            SEC_BLUE_MAGENTA:
            begin
                lvl_next = '{r: lev_t, g: lev_p, b: LEVEL_ONE};
            end
            default:
            begin
                lvl_next = '{r: LEVEL_ONE, g: lev_p, b: lev_q};
            end
        endcase
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (lvl_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lvl_reg <= lvl_next;
        end
    end

    assign lvl_valid = valid_reg;
    assign lvl       = lvl_reg;

    // One channel always sits at full level.
    `ASSERT_IMPLIES(a_one_full, clk, rst_n, valid_reg, (lvl_reg.r == LEVEL_ONE) || (lvl_reg.g == LEVEL_ONE) || (lvl_reg.b == LEVEL_ONE))

endmodule

@@ design/grhc_channel_stage.sv @@
// Value scaling of the three levels into rounded channel codes, with output register.
`include "assert_macros.svh"

module grhc_channel_stage
    import grhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        lvl_valid,
    output logic        lvl_ready,
    input  rgb_levels_t lvl,
    output logic        out_valid,
    input  logic        out_ready,
    output channel_t    red,
    output channel_t    green,
    output channel_t    blue
);

    logic     valid_reg;
    logic     valid_next;
    channel_t red_reg;
    channel_t green_reg;
    channel_t blue_reg;
    logic     load;

    // round(level * V * CHAN_MAX / 2^32), half up
    function automatic channel_t scale_level(input level_t level);
        logic [CHAN_PROD_BITS-1:0] prod;
        prod = CHAN_PROD_BITS'(level) * CHAN_PROD_BITS'(CHAN_SCALE)
             + (CHAN_PROD_BITS'(1) << (CHAN_SHIFT - 1));
        return prod[CHAN_SHIFT +: CHANNEL_BITS];
    endfunction

    assign lvl_ready = !valid_reg || out_ready;
    assign load      = lvl_valid && lvl_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= scale_level(lvl.r);
            green_reg <= scale_level(lvl.g);
            blue_reg  <= scale_level(lvl.b);
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    `ASSERT_IMPLIES(a_chan_peak, clk, rst_n, valid_reg, (red_reg <= CHAN_PEAK) && (green_reg <= CHAN_PEAK) && (blue_reg <= CHAN_PEAK))

endmodule

@@ design/golden_ratio_hue_color_generator.sv @@
// Top level of the golden-ratio hue color generator.
//
// Each transfer on the input channel (in_valid/in_ready, payload dark_palette)
// requests one color. The hue phase advances by the golden fraction, the hue
// is hue_seed plus that phase, and the HSV color (value 0.95, saturation 0.5
// light or 0.9 dark) comes out as red/green/blue on the output channel
// (out_valid/out_ready), one result per request, in order.
// hue_seed is written by a transfer on cfg_valid/cfg_ready with cfg_data;
// cfg_ready is always high. Write it only while no request is in flight.
// Pipeline: input/sextant register, level register (saturation multiply),
// output register (value multiplies). A request is registered in each stage
// in turn before its result is presented on the output channel.
// Throughput is one color per cycle; every stage loads whenever its successor
// can take data, so a stalled receiver holds the output register and backs
// the stall up through the stages to in_ready. Up to three colors are held.
// Reset clears the phase, the seed and all stage valids; no colors pend.

module golden_ratio_hue_color_generator
    import grhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SEED_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 dark_palette,
    output logic                 out_valid,
    input  logic                 out_ready,
    output channel_t             red,
    output channel_t             green,
    output channel_t             blue
);

    logic        item_valid;
    logic        item_ready;
    hue_item_t   item;
    logic        lvl_valid;
    logic        lvl_ready;
    rgb_levels_t lvl;

    assign cfg_ready = 1'b1;

    grhc_hue_gen u_hue_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dark_palette (dark_palette),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item)
    );

    grhc_level_stage u_level_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .lvl_valid  (lvl_valid),
        .lvl_ready  (lvl_ready),
        .lvl        (lvl)
    );

    grhc_channel_stage u_channel_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl       (lvl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

@@ test/golden_ratio_hue_color_generator_tb.sv @@
// Self-checking testbench for the golden-ratio hue color generator.
`timescale 1ns / 100ps

module golden_ratio_hue_color_generator_tb
    import grhc_pkg::*;
;

    localparam logic [15:0] PHASE_STEP      = 16'h9E37;
    localparam logic [15:0] SAT_HALF        = 16'd32768;
    localparam logic [15:0] SAT_NINE_TENTHS = 16'd58982;
    localparam logic [16:0] LEVEL_FULL      = 17'h10000;
    localparam longint unsigned VALUE_SCALE = 64'd62259 * 64'd255;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 90;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ROWS           = 22;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 80;

    typedef struct packed {
        channel_t red;
        channel_t green;
        channel_t blue;
    } color_t;

    typedef struct packed {
        logic        dark;
        logic        set_hue;
        logic [15:0] hue;
        logic        typed;
        color_t      color;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        dark_palette;
    logic        out_valid;
    logic        out_ready = 1'b0;
    channel_t    red;
    channel_t    green;
    channel_t    blue;

    // Typed-in color travels with the request, like payload.
    logic   row_typed;
    color_t row_color;

    logic [15:0] model_seed  = '0;
    logic [15:0] model_phase = '0;
    color_t      pending_colors[$];
    color_t      want;
    color_t      got;

    int unsigned errors;
    int unsigned colors_checked;
    int unsigned dark_requests;
    int unsigned seeds_written;
    int unsigned quiet_cycles;
    int unsigned holds_asked;
    int unsigned holds_done;
    int unsigned rx_hold_left;
    int unsigned rx_gap_left;
    bit          tx_idling;
    bit          rx_idling;

    stim_row_t directed_rows [ROWS] = '{
        '{1'b0, 1'b1, 16'h0000, 1'b1, '{8'd242, 8'd121, 8'd121}},
        '{1'b1, 1'b1, 16'h0000, 1'b1, '{8'd242, 8'd24,  8'd24 }},
        '{1'b0, 1'b1, 16'h8000, 1'b1, '{8'd121, 8'd242, 8'd242}},
        '{1'b1, 1'b1, 16'h8000, 1'b1, '{8'd24,  8'd242, 8'd242}},
        '{1'b1, 1'b1, 16'h2AAA, 1'b0, '0},
        '{1'b1, 1'b1, 16'h2AAB, 1'b0, '0},
        '{1'b0, 1'b1, 16'h5555, 1'b0, '0},
        '{1'b1, 1'b1, 16'h5556, 1'b0, '0},
        '{1'b0, 1'b1, 16'h7FFF, 1'b0, '0},
        '{1'b1, 1'b1, 16'hAAAA, 1'b0, '0},
        '{1'b0, 1'b1, 16'hAAAB, 1'b0, '0},
        '{1'b1, 1'b1, 16'hD555, 1'b0, '0},
        '{1'b0, 1'b1, 16'hD556, 1'b0, '0},
        '{1'b1, 1'b1, 16'hFFFF, 1'b0, '0},
        '{1'b0, 1'b1, 16'hFFFF, 1'b0, '0},
        '{1'b1, 1'b1, 16'h1555, 1'b0, '0},
        '{1'b0, 1'b0, 16'h0000, 1'b0, '0},
        '{1'b1, 1'b0, 16'h0000, 1'b0, '0},
        '{1'b0, 1'b0, 16'h0000, 1'b0, '0},
        '{1'b1, 1'b0, 16'h0000, 1'b0, '0},
        '{1'b1, 1'b0, 16'h0000, 1'b0, '0},
        '{1'b0, 1'b0, 16'h0000, 1'b0, '0}
    };

    golden_ratio_hue_color_generator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dark_palette (dark_palette),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic channel_t level_to_channel(input logic [16:0] level);
        longint unsigned prod;
        prod = VALUE_SCALE * 64'(level);
        return channel_t'((prod + 64'h8000_0000) >> 32);
    endfunction

    // Advance the phase and turn the new hue into a color.
    function automatic color_t next_color(input logic dark);
        logic [15:0] hue;
        logic [18:0] hue6;
        logic [15:0] frac;
        logic [15:0] sat;
        logic [31:0] sf_wide;
        logic [15:0] sf;
        logic [16:0] lv_p;
        logic [16:0] lv_q;
        logic [16:0] lv_t;
        logic [16:0] lr;
        logic [16:0] lg;
        logic [16:0] lb;
        sector_t     sec;
        color_t      c;
        model_phase = model_phase + PHASE_STEP;
        hue  = model_seed + model_phase;
        hue6 = 19'(hue) * 19'd6;
        sec  = sector_t'(hue6[18:16]);
        frac = hue6[15:0];
        sat  = dark ? SAT_NINE_TENTHS : SAT_HALF;
        sf_wide = (32'(sat) * 32'(frac) + 32'h8000) >> 16;
        sf   = (sf_wide > 32'(sat)) ? sat : sf_wide[15:0];
        lv_p = LEVEL_FULL - 17'(sat);
        lv_q = LEVEL_FULL - 17'(sf);
        lv_t = LEVEL_FULL - 17'(sat - sf);
        case (sec)
            SEC_RED_YELLOW:   begin lr = LEVEL_FULL; lg = lv_t;       lb = lv_p;       end
            SEC_YELLOW_GREEN: begin lr = lv_q;       lg = LEVEL_FULL; lb = lv_p;       end
            SEC_GREEN_CYAN:   begin lr = lv_p;       lg = LEVEL_FULL; lb = lv_t;       end
            SEC_CYAN_BLUE:    begin lr = lv_p;       lg = lv_q;       lb = LEVEL_FULL; end
            SEC_BLUE_MAGENTA: begin lr = lv_t;       lg = lv_p;       lb = LEVEL_FULL; end
            default:          begin lr = LEVEL_FULL; lg = lv_p;       lb = lv_q;       end
        endcase
        c.red   = level_to_channel(lr);
        c.green = level_to_channel(lg);
        c.blue  = level_to_channel(lb);
        return c;
    endfunction

    task automatic compare_channel(input string name, input channel_t exp_v,
                                   input channel_t act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Track transfers, predict on each request, check each color.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                model_seed = cfg_data;
                seeds_written++;
            end
            if (in_valid && in_ready)
            begin
                want = next_color(dark_palette);
                if (row_typed)
                    want = row_color;
                if (dark_palette)
                    dark_requests++;
                pending_colors.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = '{red, green, blue};
                if (pending_colors.size() == 0)
                begin
                    $error("color %0d/%0d/%0d arrived with no request pending",
                           red, green, blue);
                    errors++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    compare_channel("red", want.red, got.red);
                    compare_channel("green", want.green, got.green);
                    compare_channel("blue", want.blue, got.blue);
                    colors_checked++;
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stall bursts and, on request, one long hold-off.
    always @(posedge clk)
    begin
        if (rx_hold_left == 0 && holds_done != holds_asked)
        begin
            rx_hold_left = LONG_HOLD;
            holds_done++;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_gap_left != 0)
        begin
            rx_gap_left--;
            out_ready <= 1'b0;
        end
        else if (rx_idling && $urandom_range(0, 5) == 0)
        begin
            rx_gap_left = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_request(input logic dark, input logic typed, input color_t color);
        int gap;
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        dark_palette <= dark;
        row_typed    <= typed;
        row_color    <= color;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    // Drop valid and drain every pending color.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [15:0] seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] seed;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        dark_palette = 1'b0;
        row_typed    = 1'b0;
        row_color    = '0;
        tx_idling    = 1'b0;
        rx_idling    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pin the hue onto sextant edges by choosing the seed for each row that sets a hue.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_hue)
            begin
                wait_idle();
                write_seed(directed_rows[i].hue - (model_phase + PHASE_STEP));
            end
            send_request(directed_rows[i].dark, directed_rows[i].typed,
                         directed_rows[i].color);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:       seed = 16'h0000;
                1:       seed = 16'hFFFF;
                default: seed = 16'($urandom);
            endcase
            write_seed(seed);
            tx_idling = (ph == 0 || ph == 1 || ph == 3);
            rx_idling = (ph == 1 || ph == 2 || ph == 3);
            if (ph == 2)
                holds_asked++;
            repeat (PHASE_ITEMS)
                send_request(1'($urandom_range(0, 1)), 1'b0, '0);
        end

        wait_idle();
        $display("Checked %0d colors (%0d dark) over %0d seed writes,", colors_checked,
                 dark_requests, seeds_written);
        $display("sextant edges, phase wrap, idle bursts and one long output hold-off.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
